// ===== sv/vmep_pkg.sv =====
`timescale 1ns / 1ps
// Package for the message element parser: phase type, codes and the result record.
// No dependencies; used by every module of the block.
package vmep_pkg;

	localparam int unsigned MAX_SECTION_DEPTH_DEF = 255;
	localparam int unsigned DEPTH_W = 8;
	localparam int unsigned LEVEL_W = 9;
	localparam int unsigned LEN_W = 16;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_NLEN,
		PH_NCHR,
		PH_VHI,
		PH_VLO,
		PH_VAL
	} phase_t;

	// byte roles
	localparam logic [2:0] ROLE_TYPE = 3'd0;
	localparam logic [2:0] ROLE_NLEN = 3'd1;
	localparam logic [2:0] ROLE_NCHR = 3'd2;
	localparam logic [2:0] ROLE_VHI  = 3'd3;
	localparam logic [2:0] ROLE_VLO  = 3'd4;
	localparam logic [2:0] ROLE_VAL  = 3'd5;
	localparam logic [2:0] ROLE_END  = 3'd6;

	// element types, also the low bits of a type byte
	localparam logic [2:0] EL_NONE       = 3'd0;
	localparam logic [2:0] EL_SEC_START  = 3'd1;
	localparam logic [2:0] EL_SEC_END    = 3'd2;
	localparam logic [2:0] EL_KEY_VALUE  = 3'd3;
	localparam logic [2:0] EL_LIST_START = 3'd4;
	localparam logic [2:0] EL_LIST_ITEM  = 3'd5;
	localparam logic [2:0] EL_LIST_END   = 3'd6;
	localparam logic [2:0] EL_MSG_END    = 3'd7;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_BAD   = 2'd1;
	localparam logic [1:0] ERR_NAME  = 2'd2;
	localparam logic [1:0] ERR_DEPTH = 2'd3;

	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;

	typedef struct packed {
		logic [2:0]         role;
		logic [7:0]         data;
		logic [2:0]         done;
		logic [LEVEL_W-1:0] level;
		logic [1:0]         err;
	} result_t;

endpackage

// ===== sv/vmep_core.sv =====
`timescale 1ns / 1ps
// Parser state registers and the per-byte decode that forms one result.
// Depends on vmep_pkg.
module vmep_core #(
	parameter int unsigned MAX_SECTION_DEPTH = vmep_pkg::MAX_SECTION_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              op,
	input  logic [7:0]        data_byte,
	output vmep_pkg::result_t res
);

	localparam logic [vmep_pkg::DEPTH_W-1:0] DepthCap =
		(MAX_SECTION_DEPTH > 255) ? 8'd255 : 8'(MAX_SECTION_DEPTH);

	vmep_pkg::phase_t              phase_q, phase_d;
	logic [2:0]                    elem_q, elem_d;
	logic [vmep_pkg::LEN_W-1:0]    remain_q, remain_d;
	logic [7:0]                    len_hi_q, len_hi_d;
	logic [vmep_pkg::DEPTH_W-1:0]  depth_q, depth_d, depth_post;
	logic                          list_q, list_d, list_post;
	logic [1:0]                    err_q, err_d;

	logic [1:0]                    fault;
	logic [1:0]                    err_out;
	logic [vmep_pkg::LEN_W-1:0]    remain_dec;
	logic [vmep_pkg::LEN_W-1:0]    vlen;
	logic [2:0]                    name_done;
	logic                          type_ok;

	assign remain_dec = remain_q - 16'd1;
	assign vlen       = {len_hi_q, data_byte};
	assign name_done  = (elem_q == vmep_pkg::EL_KEY_VALUE) ? vmep_pkg::EL_NONE : elem_q;
	assign type_ok    = (data_byte[7:3] == 5'd0);

	// error raised by this item, if none is pending yet
	always_comb begin
		fault = vmep_pkg::ERR_NONE;
		if (err_q == vmep_pkg::ERR_NONE) begin
			if (op) begin
				if (phase_q != vmep_pkg::PH_TYPE || list_q || depth_q != '0)
					fault = vmep_pkg::ERR_BAD;
			end else begin
				case (phase_q)
					vmep_pkg::PH_TYPE: begin
						if (!type_ok) begin
							fault = vmep_pkg::ERR_BAD;
						end else begin
							case (data_byte[2:0])
								vmep_pkg::EL_SEC_START: begin
									if (list_q)
										fault = vmep_pkg::ERR_BAD;
									else if (depth_q >= DepthCap)
										fault = vmep_pkg::ERR_DEPTH;
								end
								vmep_pkg::EL_SEC_END: begin
									if (depth_q == '0 || list_q)
										fault = vmep_pkg::ERR_BAD;
								end
								vmep_pkg::EL_KEY_VALUE, vmep_pkg::EL_LIST_START: begin
									if (list_q)
										fault = vmep_pkg::ERR_BAD;
								end
								vmep_pkg::EL_LIST_ITEM, vmep_pkg::EL_LIST_END: begin
									if (!list_q)
										fault = vmep_pkg::ERR_BAD;
								end
								default: fault = vmep_pkg::ERR_BAD;
							endcase
						end
					end
					vmep_pkg::PH_NCHR: begin
						if (!(data_byte inside {[vmep_pkg::PRINT_LO:vmep_pkg::PRINT_HI]}))
							fault = vmep_pkg::ERR_NAME;
					end
					default: fault = vmep_pkg::ERR_NONE;
				endcase
			end
		end
	end

	assign err_out = (err_q != vmep_pkg::ERR_NONE) ? err_q : fault;

	// next state
	always_comb begin
		phase_d    = phase_q;
		elem_d     = elem_q;
		remain_d   = remain_q;
		len_hi_d   = len_hi_q;
		depth_post = depth_q;
		list_post  = list_q;
		err_d      = err_out;
		if (!op && err_out == vmep_pkg::ERR_NONE) begin
			case (phase_q)
				vmep_pkg::PH_TYPE: begin
					case (data_byte[2:0])
						vmep_pkg::EL_SEC_START: begin
							depth_post = depth_q + 8'd1;
							elem_d     = vmep_pkg::EL_SEC_START;
							phase_d    = vmep_pkg::PH_NLEN;
						end
						vmep_pkg::EL_SEC_END: depth_post = depth_q - 8'd1;
						vmep_pkg::EL_KEY_VALUE, vmep_pkg::EL_LIST_START: begin
							elem_d  = data_byte[2:0];
							phase_d = vmep_pkg::PH_NLEN;
						end
						vmep_pkg::EL_LIST_ITEM: begin
							elem_d  = vmep_pkg::EL_LIST_ITEM;
							phase_d = vmep_pkg::PH_VHI;
						end
						vmep_pkg::EL_LIST_END: list_post = 1'b0;
						default: phase_d = phase_q;
					endcase
				end
				vmep_pkg::PH_NLEN, vmep_pkg::PH_NCHR: begin
					if (phase_q == vmep_pkg::PH_NLEN)
						remain_d = {8'd0, data_byte};
					else
						remain_d = remain_dec;
					if ((phase_q == vmep_pkg::PH_NLEN && data_byte == 8'd0) ||
					    (phase_q == vmep_pkg::PH_NCHR && remain_dec == '0)) begin
						// name complete: a key-value goes on to its value
						if (elem_q == vmep_pkg::EL_KEY_VALUE) begin
							phase_d = vmep_pkg::PH_VHI;
						end else begin
							if (elem_q == vmep_pkg::EL_LIST_START)
								list_post = 1'b1;
							phase_d = vmep_pkg::PH_TYPE;
						end
					end else begin
						phase_d = vmep_pkg::PH_NCHR;
					end
				end
				vmep_pkg::PH_VHI: begin
					len_hi_d = data_byte;
					phase_d  = vmep_pkg::PH_VLO;
				end
				vmep_pkg::PH_VLO: begin
					remain_d = vlen;
					phase_d  = (vlen == '0) ? vmep_pkg::PH_TYPE : vmep_pkg::PH_VAL;
				end
				default: begin
					remain_d = remain_dec;
					if (remain_dec == '0)
						phase_d = vmep_pkg::PH_TYPE;
				end
			endcase
		end
	end

	assign depth_d = op ? '0 : depth_post;
	assign list_d  = op ? 1'b0 : list_post;

	// outputs
	always_comb begin
		res.data  = op ? 8'd0 : data_byte;
		res.err   = err_out;
		res.level = vmep_pkg::LEVEL_W'(depth_post) + vmep_pkg::LEVEL_W'(list_post);
		res.role  = vmep_pkg::ROLE_TYPE;
		res.done  = vmep_pkg::EL_NONE;
		if (op) begin
			res.role = vmep_pkg::ROLE_END;
			if (err_out == vmep_pkg::ERR_NONE)
				res.done = vmep_pkg::EL_MSG_END;
		end else if (err_q == vmep_pkg::ERR_NONE) begin
			case (phase_q)
				vmep_pkg::PH_TYPE: begin
					res.role = vmep_pkg::ROLE_TYPE;
					if (type_ok && (data_byte[2:0] == vmep_pkg::EL_SEC_END ||
					                data_byte[2:0] == vmep_pkg::EL_LIST_END))
						res.done = data_byte[2:0];
				end
				vmep_pkg::PH_NLEN: begin
					res.role = vmep_pkg::ROLE_NLEN;
					if (data_byte == 8'd0)
						res.done = name_done;
				end
				vmep_pkg::PH_NCHR: begin
					res.role = vmep_pkg::ROLE_NCHR;
					if (remain_dec == '0)
						res.done = name_done;
				end
				vmep_pkg::PH_VHI: res.role = vmep_pkg::ROLE_VHI;
				vmep_pkg::PH_VLO: begin
					res.role = vmep_pkg::ROLE_VLO;
					if (vlen == '0)
						res.done = elem_q;
				end
				default: begin
					res.role = vmep_pkg::ROLE_VAL;
					if (remain_dec == '0)
						res.done = elem_q;
				end
			endcase
			if (fault != vmep_pkg::ERR_NONE)
				res.done = vmep_pkg::EL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= vmep_pkg::PH_TYPE;
			elem_q   <= vmep_pkg::EL_NONE;
			remain_q <= '0;
			len_hi_q <= '0;
			depth_q  <= '0;
			list_q   <= 1'b0;
			err_q    <= vmep_pkg::ERR_NONE;
		end else if (fire) begin
			phase_q  <= op ? vmep_pkg::PH_TYPE : phase_d;
			elem_q   <= op ? vmep_pkg::EL_NONE : elem_d;
			remain_q <= op ? '0 : remain_d;
			len_hi_q <= op ? '0 : len_hi_d;
			depth_q  <= depth_d;
			list_q   <= list_d;
			err_q    <= op ? vmep_pkg::ERR_NONE : err_d;
		end
	end

endmodule

// ===== sv/vmep_out_skid.sv =====
`timescale 1ns / 1ps
// Result register with a skid stage; input ready comes from a flop.
// Depends on vmep_pkg.
module vmep_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vmep_pkg::result_t in_res,
	output logic              out_valid,
	input  logic              out_ready,
	output vmep_pkg::result_t out_res
);

	logic              out_v_q;
	logic              skid_v_q;
	vmep_pkg::result_t out_q;
	vmep_pkg::result_t skid_q;
	logic              in_fire;
	logic              out_fire;

	assign in_ready  = !skid_v_q;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_v_q && out_ready;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_fire) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			if (out_v_q)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (in_fire)
				out_q <= in_res;
		end else if (in_fire) begin
			if (out_v_q)
				skid_q <= in_res;
			else
				out_q <= in_res;
		end
	end

endmodule

// ===== sv/vici_message_element_parser.sv =====
`timescale 1ns / 1ps
// Message element parser: takes one body byte or end marker per cycle while s_tready is
// high and returns one result per request. Throughput is one request per clock while the
// skid stage is empty: the parser state (phase, length counter, section depth, list flag,
// sticky error) is updated from the incoming byte, and the result is registered in an output
// register backed by a one-entry skid stage, so s_tready depends only on that skid flop and
// stays high while a single result waits downstream. No clearing pass is needed after
// reset; the block is ready as soon as reset is released.
// Depends on vmep_pkg, vmep_core and vmep_out_skid.
module vici_message_element_parser #(
	parameter int unsigned MAX_SECTION_DEPTH = vmep_pkg::MAX_SECTION_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] op (1 = end of message)
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_out, [10:8] element_done,
	                               // [19:11] nest_level, [21:20] error_code, [23:22] zero
	output logic [2:0]  m_tuser    // [2:0] byte_role
);

	vmep_pkg::result_t core_res;
	vmep_pkg::result_t out_res;
	logic              req_fire;

	// state advances only on an accepted request
	assign req_fire = s_tvalid && s_tready;

	vmep_core #(
		.MAX_SECTION_DEPTH(MAX_SECTION_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (req_fire),
		.op       (s_tuser[0]),
		.data_byte(s_tdata),
		.res      (core_res)
	);

	// hold results here while the consumer stalls
	vmep_out_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_res   (core_res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	// pack fields, lowest first
	assign m_tdata = {2'b00, out_res.err, out_res.level, out_res.done, out_res.data};
	assign m_tuser = out_res.role;

endmodule

// ===== sv/vmep_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the message element parser, bound to the top level.
// Depends on vmep_pkg and vici_message_element_parser.
module vmep_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// end marker reports either message end or an error, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == vmep_pkg::ROLE_END |->
		((m_tdata[10:8] == vmep_pkg::EL_MSG_END) != (m_tdata[21:20] != vmep_pkg::ERR_NONE)))
		else $error("end marker result inconsistent");

	// message end only on the end marker
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != vmep_pkg::ROLE_END |-> m_tdata[10:8] != vmep_pkg::EL_MSG_END)
		else $error("message end on a body byte");

	// no element completes once an error is set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[21:20] != vmep_pkg::ERR_NONE && m_tuser != vmep_pkg::ROLE_END
		|-> m_tdata[10:8] == vmep_pkg::EL_NONE)
		else $error("element completed under error");

endmodule

bind vici_message_element_parser vmep_checker u_vmep_checker (.*);
